### hw/rtl/smed_pkg.sv
// smed_pkg: shared constants and types of the set median engine.
// Used by smed_radix and set_median_engine. No dependencies.
package smed_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  typedef struct packed {
    logic init;
    logic data_vld;
    logic pass_done;
  } rdx_ctrl_t;

endpackage

### hw/rtl/smed_ram.sv
// smed_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module smed_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/smed_radix.sv
// smed_radix: bitwise radix selection of two order statistics over stored samples.
// Depends on smed_pkg. One pass per sample bit, fed by the sample RAM read port.
module smed_radix #(
  parameter int unsigned MAX_SAMPLES = smed_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = smed_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  smed_pkg::rdx_ctrl_t    ctrl,
  input  logic [CNT_W-1:0]       rank_a,
  input  logic [CNT_W-1:0]       rank_b,
  input  logic [SAMPLE_BITS-1:0] rd_data,
  output logic                   last_pass,
  output logic [SAMPLE_BITS:0]   median
);

  localparam logic [SAMPLE_BITS-1:0] SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [SAMPLE_BITS-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [SAMPLE_BITS-1:0] msk_r, msk_nxt, bsel_r, bsel_nxt;
  logic [CNT_W-1:0]       ra_r, ra_nxt, rb_r, rb_nxt;
  logic [CNT_W-1:0]       ca_r, ca_nxt, cb_r, cb_nxt;
  logic [SAMPLE_BITS-1:0] key, va, vb;
  logic                   hit_a, hit_b;

  assign key   = rd_data ^ SIGN;
  assign hit_a = (((key ^ pa_r) & msk_r) == '0) && ((key & bsel_r) == '0);
  assign hit_b = (((key ^ pb_r) & msk_r) == '0) && ((key & bsel_r) == '0);

  always_comb begin
    pa_nxt   = pa_r;
    pb_nxt   = pb_r;
    ra_nxt   = ra_r;
    rb_nxt   = rb_r;
    ca_nxt   = ca_r;
    cb_nxt   = cb_r;
    msk_nxt  = msk_r;
    bsel_nxt = bsel_r;
    if (ctrl.init) begin
      pa_nxt   = '0;
      pb_nxt   = '0;
      ra_nxt   = rank_a;
      rb_nxt   = rank_b;
      ca_nxt   = '0;
      cb_nxt   = '0;
      msk_nxt  = '0;
      bsel_nxt = SIGN;
    end else if (ctrl.data_vld) begin
      ca_nxt = ca_r + CNT_W'(hit_a);
      cb_nxt = cb_r + CNT_W'(hit_b);
    end else if (ctrl.pass_done) begin
      if (ra_r >= ca_r) begin
        pa_nxt = pa_r | bsel_r;
        ra_nxt = ra_r - ca_r;
      end
      if (rb_r >= cb_r) begin
        pb_nxt = pb_r | bsel_r;
        rb_nxt = rb_r - cb_r;
      end
      ca_nxt   = '0;
      cb_nxt   = '0;
      msk_nxt  = {1'b1, msk_r[SAMPLE_BITS-1:1]};
      bsel_nxt = {1'b0, bsel_r[SAMPLE_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r   <= '0;
      cb_r   <= '0;
      msk_r  <= '0;
      bsel_r <= SIGN;
    end else begin
      ca_r   <= ca_nxt;
      cb_r   <= cb_nxt;
      msk_r  <= msk_nxt;
      bsel_r <= bsel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
  end

  assign va        = pa_r ^ SIGN;
  assign vb        = pb_r ^ SIGN;
  assign last_pass = bsel_r[0];
  assign median    = {va[SAMPLE_BITS-1], va} + {vb[SAMPLE_BITS-1], vb};

endmodule

### hw/rtl/set_median_engine.sv
// set_median_engine: top level; loads a sample set into RAM and finds its median.
// Depends on smed_pkg, smed_ram and smed_radix.
//
// Usage: each slave-side transaction carries one signed sample in in_tdata;
// in_tlast marks the final sample of a set. Samples load one per cycle into
// the sample RAM. Samples beyond MAX_SAMPLES are dropped and flagged.
// After the last sample the block selects the two middle order statistics
// by a bitwise radix search: one pass per sample bit, each pass reading all
// n stored samples through the single RAM read port, then a drain state and
// a decide state. After the last pass the result is loaded into the output
// register and one master-side transaction carries the doubled median,
// the count and the overflow flag. in_tready is low during selection and
// while a finished result waits for the output register.
// The result sits in an output register; a new set loads while it waits,
// and a stalled receiver holds the next result in the engine until taken.
// Reset clears the fill count, the overflow flag and the output valid; the
// RAM needs no clearing since only entries of the current set are read.
module set_median_engine #(
  parameter int unsigned MAX_SAMPLES = smed_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_BITS = smed_pkg::SAMPLE_BITS_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int unsigned MED_W = SAMPLE_BITS + 1,
  localparam int unsigned IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((MED_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // sample
  input  logic             in_tlast,   // last_sample
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // median_doubled, set_count
  output logic             out_tuser   // status
);

  typedef enum logic [4:0] {
    S_LOAD   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_DECIDE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic                 rd_vld_r;
  logic                 out_vld_r, out_vld_nxt;
  logic [MED_W-1:0]     out_med_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic                 out_sts_r;
  logic                 in_acc, store_en, out_load;
  logic [CNT_W-1:0]     n_next, half, rank_a, rank_b;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                 last_pass;
  logic [MED_W-1:0]     median;
  smed_pkg::rdx_ctrl_t  rctl;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign store_en  = in_acc && (fill_r < CNT_W'(MAX_SAMPLES));
  assign n_next    = store_en ? fill_r + CNT_W'(1) : fill_r;
  assign half      = n_next >> 1;
  assign rank_b    = half;
  assign rank_a    = n_next[0] ? half : half - CNT_W'(1);
  assign out_load  = (state_r == S_DONE) && (!out_vld_r || out_tready);

  assign rctl.init      = in_acc && in_tlast;
  assign rctl.data_vld  = rd_vld_r;
  assign rctl.pass_done = (state_r == S_DECIDE);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    addr_nxt    = addr_r;
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          fill_nxt = n_next;
          if (!store_en) begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            addr_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        addr_nxt = addr_r + AW'(1);
        if (CNT_W'(addr_r) == fill_r - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        addr_nxt  = '0;
        state_nxt = last_pass ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        if (out_load) begin
          out_vld_nxt = 1'b1;
          fill_nxt    = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      fill_r    <= '0;
      ovf_r     <= 1'b0;
      addr_r    <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      ovf_r     <= ovf_nxt;
      addr_r    <= addr_nxt;
      rd_vld_r  <= (state_r == S_SCAN);
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_med_r <= median;
      out_cnt_r <= fill_r;
      out_sts_r <= ovf_r;
    end
  end

  smed_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_tdata[SAMPLE_BITS-1:0]),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  smed_radix #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_radix (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (rctl),
    .rank_a    (rank_a),
    .rank_b    (rank_b),
    .rd_data   (rd_data),
    .last_pass (last_pass),
    .median    (median)
  );

  always_comb begin
    out_tdata                          = '0;
    out_tdata[MED_W-1:0]               = out_med_r;
    out_tdata[MED_W+CNT_W-1:MED_W]     = out_cnt_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_sts_r;

endmodule

### verif/set_median_engine_tb.sv
// set_median_engine_tb: self-checking testbench of the set median engine.
// Streams directed and random sample sets with random idling on both sides and
// checks results against a sorting predictor or typed rows. Depends on smed_pkg.
module set_median_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAP        = smed_pkg::MAX_SAMPLES_DEF;
  localparam int SMP_W          = smed_pkg::SAMPLE_BITS_DEF;
  localparam int CNT_W          = $clog2(SET_CAP + 1);
  localparam int MED_W          = SMP_W + 1;
  localparam int IN_W           = ((SMP_W + 7) / 8) * 8;
  localparam int OUT_W          = ((MED_W + CNT_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS   = 800;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int N_DIRECTED     = 24;

  typedef struct packed {
    logic [MED_W-1:0] med;
    logic [CNT_W-1:0] cnt;
    logic             st;
  } median_result_t;

  typedef struct packed {
    logic [SMP_W-1:0] smp;
    logic             lst;
    logic             typed;
    median_result_t   res;
  } stim_row_t;

  localparam median_result_t NO_RES = '0;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{33'h0_FFFF_FFFE, 9'd1, 1'b0}},
    '{32'h8000_0000, 1'b1, 1'b1, '{33'h1_0000_0000, 9'd1, 1'b0}},
    '{32'h0000_0000, 1'b1, 1'b1, '{33'h0_0000_0000, 9'd1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{33'h1_FFFF_FFFE, 9'd1, 1'b0}},
    '{32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{33'h1_FFFF_FFFF, 9'd2, 1'b0}},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, '{33'h0_FFFF_FFFE, 9'd2, 1'b0}},
    '{32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{32'h8000_0000, 1'b1, 1'b1, '{33'h1_0000_0000, 9'd2, 1'b0}},
    '{32'h0005_0000, 1'b0, 1'b0, NO_RES},
    '{32'hFFFD_0000, 1'b0, 1'b0, NO_RES},
    '{32'h0001_0000, 1'b0, 1'b0, NO_RES},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, NO_RES},
    '{32'h8000_0000, 1'b1, 1'b0, NO_RES},
    '{32'h0000_0003, 1'b0, 1'b0, NO_RES},
    '{32'h0000_0001, 1'b0, 1'b0, NO_RES},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, NO_RES},
    '{32'h0000_0002, 1'b1, 1'b0, NO_RES},
    '{32'h0000_0005, 1'b0, 1'b0, NO_RES},
    '{32'h0000_0005, 1'b0, 1'b0, NO_RES},
    '{32'h0000_0005, 1'b1, 1'b0, NO_RES},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, NO_RES},
    '{32'h5555_5555, 1'b1, 1'b0, NO_RES}
  };

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;   // sample
  logic             in_tlast   = 1'b0; // last_sample
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;         // median_doubled, set_count
  logic             out_tuser;         // status

  logic signed [SMP_W-1:0] set_samples [SET_CAP];
  int                      fill_level;
  logic                    overflow_flag;
  median_result_t          pending_medians [$];
  median_result_t          got_res;
  median_result_t          want_res;
  logic [SMP_W-1:0]        prev_sample;
  int                      mismatch_count;
  int                      idle_cycles;
  int                      rx_stall;
  bit                      rx_steady;
  bit                      tx_steady;

  set_median_engine #(
    .MAX_SAMPLES(SET_CAP),
    .SAMPLE_BITS(SMP_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic median_result_t median_of_set();
    logic signed [SMP_W-1:0] srt [SET_CAP];
    logic signed [SMP_W-1:0] key;
    int                      j;
    int                      mid;
    median_result_t          res;
    for (int i = 0; i < fill_level; i++) srt[i] = set_samples[i];
    for (int i = 1; i < fill_level; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && key < srt[j-1]) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    mid = fill_level / 2;
    if (fill_level % 2 == 0) begin
      res.med = {srt[mid][SMP_W-1], srt[mid]} + {srt[mid-1][SMP_W-1], srt[mid-1]};
    end else begin
      res.med = {srt[mid], 1'b0};
    end
    res.cnt = CNT_W'(fill_level);
    res.st  = overflow_flag;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return $urandom;
      4, 5:       return SMP_W'($signed($urandom_range(0, 16)) - 8);
      6: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      7:          return prev_sample;
      default:    return $signed($urandom) >>> 7;
    endcase
  endfunction

  task automatic send_sample(input logic [SMP_W-1:0] smp, input logic lst,
                             input logic use_typed, input median_result_t typed_res);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(smp);
    in_tlast  <= lst;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    prev_sample = smp;
    if (fill_level < SET_CAP) begin
      set_samples[fill_level] = smp;
      fill_level++;
    end else begin
      overflow_flag = 1'b1;
    end
    if (lst) begin
      pending_medians.push_back(use_typed ? typed_res : median_of_set());
      fill_level    = 0;
      overflow_flag = 1'b0;
    end
    gap = (tx_steady || $urandom_range(0, 99) < 50) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 399) == 0) rx_steady = ~rx_steady;
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else begin
      out_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 99) < 25) rx_stall = pick_gap();
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.med = out_tdata[MED_W-1:0];
      got_res.cnt = out_tdata[MED_W +: CNT_W];
      got_res.st  = out_tuser;
      if (pending_medians.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got_res);
        mismatch_count++;
      end else begin
        want_res = pending_medians.pop_front();
        if (got_res.med !== want_res.med) begin
          $display("%0t: median_doubled expected %h actual %h", $time, want_res.med,
                   got_res.med);
          mismatch_count++;
        end
        if (got_res.cnt !== want_res.cnt) begin
          $display("%0t: set_count expected %0d actual %0d", $time, want_res.cnt,
                   got_res.cnt);
          mismatch_count++;
        end
        if (got_res.st !== want_res.st) begin
          $display("%0t: status expected %b actual %b", $time, want_res.st, got_res.st);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("set_median_engine_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int items_sent;
    int set_idx;
    int set_len;
    fill_level     = 0;
    overflow_flag  = 1'b0;
    prev_sample    = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    rx_stall       = 0;
    rx_steady      = 1'b0;
    tx_steady      = 1'b0;
    items_sent     = 0;
    set_idx        = 0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) begin
      send_sample(DIRECTED_ROWS[k].smp, DIRECTED_ROWS[k].lst, DIRECTED_ROWS[k].typed,
                  DIRECTED_ROWS[k].res);
    end
    wait_results_drained();

    while (items_sent < RANDOM_ITEMS) begin
      if (set_idx == 4) set_len = SET_CAP;
      else if (set_idx == 12) set_len = SET_CAP + 1;
      else if (set_idx == 8) set_len = SET_CAP + $urandom_range(2, 40);
      else if ($urandom_range(0, 99) < 85) set_len = $urandom_range(1, 8);
      else set_len = $urandom_range(9, 48);
      if ($urandom_range(0, 19) == 0) wait_results_drained();
      tx_steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++) begin
        send_sample(rand_sample(), k == set_len - 1, 1'b0, NO_RES);
      end
      items_sent += set_len;
      set_idx++;
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("set_median_engine_tb OK");
    end else begin
      $display("set_median_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
